// ===== src/gsaa_pkg.sv =====
// Shared types, constants and tables for the Gaussian splat activation pipeline.
`default_nettype none
package gsaa_pkg;

   localparam int FIELD_W = 16;
   localparam int REQ_W   = 11 * FIELD_W;
   localparam int RSP_W   = 224;

   localparam int EXP_N_W = 6;
   localparam int MANT_W  = 33;
   localparam int RES_W   = 32;

   localparam logic signed [32:0] LN2_Q32 = 33'sd2977044472;
   // 2^21 / ln2, i.e. 1/ln2 in Q1.21, close enough for a one-step quotient fix
   localparam logic [21:0]        INV_LN2 = 22'd3025550;
   localparam logic signed [31:0] C0_Q32  = 32'sd1211587905;

   localparam int TAYLOR_LAST = 13;
   localparam int EXP_LAT     = 5 + 3 * (TAYLOR_LAST - 1);
   localparam int QUAT_STEPS  = 15;
   localparam int QUAT_LAT    = 3 + QUAT_STEPS;
   localparam int DIV_STEPS   = 17;
   localparam int OPAC_LAT    = EXP_LAT + 2 + DIV_STEPS;
   localparam int SCALE_LAT   = EXP_LAT + 1;
   localparam int COLOR_LAT   = 2;
   localparam int PIPE_LAT    = OPAC_LAT;

   typedef logic signed [FIELD_W-1:0] field_type;

   typedef struct packed {
      logic signed [EXP_N_W-1:0] n;
      logic [MANT_W-1:0]         m;
   } exp_type;

   typedef struct packed {
      logic [3:0][FIELD_W-1:0] part;
      logic                    zero;
   } quat_type;

   // floor(2^32 / k) for the Taylor term divisors
   function automatic logic [31:0] recip_of(input int k);
      logic [31:0] r;
      unique case (k)
         2:       r = 32'd2147483648;
         3:       r = 32'd1431655765;
         4:       r = 32'd1073741824;
         5:       r = 32'd858993459;
         6:       r = 32'd715827882;
         7:       r = 32'd613566756;
         8:       r = 32'd536870912;
         9:       r = 32'd477218588;
         10:      r = 32'd429496729;
         11:      r = 32'd390451572;
         12:      r = 32'd357913941;
         13:      r = 32'd330382099;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/gsaa_exp.sv =====
// Pipelined e^(v/2048) split into exponent and Q.32 mantissa via range reduction and Taylor sum.
`default_nettype none
module gsaa_exp (
   input  logic                clock,
   input  logic                en,
   input  gsaa_pkg::field_type v_in,
   output gsaa_pkg::exp_type   res_out
);

   localparam int NSTEP = gsaa_pkg::TAYLOR_LAST - 1;

   typedef struct packed {
      logic signed [gsaa_pkg::EXP_N_W-1:0] n;
      logic [gsaa_pkg::RES_W-1:0]          r;
      logic [gsaa_pkg::MANT_W-1:0]         sum;
      logic [gsaa_pkg::RES_W-1:0]          term;
   } tay_type;

   logic signed [15:0] v1_ff, v2_ff;
   logic signed [38:0] prod_ff, prod_in;
   logic signed [5:0]  nest_in, nest2_ff, nest3_ff;
   logic signed [38:0] nl_ff, nl_in;
   logic signed [39:0] rem_ff, rem_in;
   logic signed [5:0]  n4_ff, n4_in;
   logic [31:0]        r4_ff, r4_in;
   tay_type            t1_ff, t1_in;
   tay_type            a_ff [NSTEP];
   tay_type            b_ff [NSTEP];
   tay_type            c_ff [NSTEP];
   tay_type            a_in [NSTEP];
   tay_type            c_in [NSTEP];
   logic [63:0]        pm_ff [NSTEP];
   logic [63:0]        pm_in [NSTEP];

   assign prod_in = 39'(v_in) * 39'(signed'({1'b0, gsaa_pkg::INV_LN2}));
   assign nest_in = prod_ff[37:32];
   assign nl_in   = 39'(nest_in) * 39'(gsaa_pkg::LN2_Q32);
   assign rem_in  = 40'(signed'({v2_ff, 21'b0})) - 40'(nl_ff);

   // quotient estimate is off by at most one either way
   always_comb begin
      if (rem_ff < 0) begin
         n4_in = nest3_ff - 6'sd1;
         r4_in = 32'(rem_ff + 40'(gsaa_pkg::LN2_Q32));
      end else if (rem_ff >= 40'(gsaa_pkg::LN2_Q32)) begin
         n4_in = nest3_ff + 6'sd1;
         r4_in = 32'(rem_ff - 40'(gsaa_pkg::LN2_Q32));
      end else begin
         n4_in = nest3_ff;
         r4_in = rem_ff[31:0];
      end
   end

   always_comb begin
      t1_in.n    = n4_ff;
      t1_in.r    = r4_ff;
      t1_in.term = r4_ff;
      t1_in.sum  = {1'b1, r4_ff};
   end

   // three stages per term: r product, reciprocal product, quotient fix and accumulate
   always_comb begin
      tay_type     src;
      logic [63:0] pt;
      logic [31:0] qe, qrem, q;
      for (int j = 0; j < NSTEP; j++) begin
         src = (j == 0) ? t1_ff : c_ff[j-1];
         pt = 64'(src.term) * 64'(src.r);
         a_in[j] = src;
         a_in[j].term = pt[63:32];
         pm_in[j] = 64'(a_ff[j].term) * 64'(gsaa_pkg::recip_of(j + 2));
         qe = pm_ff[j][63:32];
         qrem = b_ff[j].term - 32'(qe * 32'(j + 2));
         q = (qrem >= 32'(j + 2)) ? qe + 32'd1 : qe;
         c_in[j] = b_ff[j];
         c_in[j].term = q;
         c_in[j].sum = b_ff[j].sum + 33'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v1_ff    <= v_in;
         prod_ff  <= prod_in;
         v2_ff    <= v1_ff;
         nest2_ff <= nest_in;
         nl_ff    <= nl_in;
         nest3_ff <= nest2_ff;
         rem_ff   <= rem_in;
         n4_ff    <= n4_in;
         r4_ff    <= r4_in;
         t1_ff    <= t1_in;
         for (int j = 0; j < NSTEP; j++) begin
            a_ff[j]  <= a_in[j];
            b_ff[j]  <= a_ff[j];
            pm_ff[j] <= pm_in[j];
            c_ff[j]  <= c_in[j];
         end
      end
   end

   assign res_out.n = c_ff[NSTEP-1].n;
   assign res_out.m = c_ff[NSTEP-1].sum;

endmodule
`default_nettype wire

// ===== src/gsaa_quat.sv =====
// Pipelined quaternion normaliser: exact rounded q / sqrt(S) by a bit-per-stage search.
`default_nettype none
module gsaa_quat (
   input  logic                         clock,
   input  logic                         en,
   input  logic [3:0][15:0]             q_in,
   output gsaa_pkg::quat_type           res_out
);

   localparam int NL = 4;
   localparam int NS = gsaa_pkg::QUAT_STEPS;

   typedef struct packed {
      logic [14:0]        cur;
      logic signed [49:0] a1;
      logic [60:0]        a2;
   } lane_type;

   logic [30:0]        sq_ff  [NL];
   logic [30:0]        sq_in  [NL];
   logic [NL-1:0]      neg1_ff;
   logic [32:0]        s2_ff, s2_in;
   logic [60:0]        rhs2_ff [NL];
   logic [NL-1:0]      neg2_ff;
   lane_type           ln_ff  [NS][NL];
   lane_type           ln_in  [NS][NL];
   logic [32:0]        s_ff   [NS];
   logic [60:0]        rhs_ff [NS][NL];
   logic [NL-1:0]      neg_ff [NS];
   gsaa_pkg::quat_type res_ff, res_in;

   always_comb begin
      logic [15:0] mag;
      s2_in = '0;
      for (int i = 0; i < NL; i++) begin
         mag = q_in[i][15] ? 16'(-q_in[i]) : q_in[i];
         sq_in[i] = 31'(32'(mag) * 32'(mag));
         s2_in = s2_in + 33'(sq_ff[i]);
      end
   end

   // odd = 2*cur - 1; a1 = odd*S and a2 = odd^2*S are carried so each trial is adds and shifts
   always_comb begin
      lane_type           pl;
      logic [32:0]        ps;
      logic [60:0]        prhs;
      logic signed [65:0] trial;
      int                 b;
      for (int t = 0; t < NS; t++) begin
         b = NS - 1 - t;
         ps = (t == 0) ? s2_ff : s_ff[t-1];
         for (int i = 0; i < NL; i++) begin
            if (t == 0) begin
               pl.cur = '0;
               pl.a1  = -$signed(50'(s2_ff));
               pl.a2  = 61'(s2_ff);
               prhs   = rhs2_ff[i];
            end else begin
               pl   = ln_ff[t-1][i];
               prhs = rhs_ff[t-1][i];
            end
            trial = $signed(66'(pl.a2)) + (66'(pl.a1) <<< (b + 2))
                    + $signed(66'(ps) << (2 * b + 2));
            ln_in[t][i] = pl;
            if (trial <= $signed(66'(prhs))) begin
               ln_in[t][i].cur = pl.cur | 15'(1 << b);
               ln_in[t][i].a2  = trial[60:0];
               ln_in[t][i].a1  = pl.a1 + $signed(50'(ps) << (b + 1));
            end
         end
      end
   end

   always_comb begin
      lane_type fl;
      res_in.zero = (s_ff[NS-1] == '0);
      for (int i = 0; i < NL; i++) begin
         fl = ln_ff[NS-1][i];
         if (res_in.zero) begin
            res_in.part[i] = '0;
         end else if (neg_ff[NS-1][i]) begin
            res_in.part[i] = 16'(-{1'b0, fl.cur});
         end else begin
            res_in.part[i] = 16'(fl.cur);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NL; i++) begin
            sq_ff[i]   <= sq_in[i];
            neg1_ff[i] <= q_in[i][15];
            rhs2_ff[i] <= {sq_ff[i], 30'b0};
         end
         s2_ff   <= s2_in;
         neg2_ff <= neg1_ff;
         for (int t = 0; t < NS; t++) begin
            s_ff[t]   <= (t == 0) ? s2_ff : s_ff[t-1];
            neg_ff[t] <= (t == 0) ? neg2_ff : neg_ff[t-1];
            for (int i = 0; i < NL; i++) begin
               ln_ff[t][i]  <= ln_in[t][i];
               rhs_ff[t][i] <= (t == 0) ? rhs2_ff[i] : rhs_ff[t-1][i];
            end
         end
         res_ff <= res_in;
      end
   end

   assign res_out = res_ff;

endmodule
`default_nettype wire

// ===== src/gsaa_opac.sv =====
// Opacity sigmoid: exponential of -|logit|, then a pipelined restoring divide 2^48 / (2^32 + E).
`default_nettype none
module gsaa_opac (
   input  logic                clock,
   input  logic                en,
   input  gsaa_pkg::field_type v_in,
   output logic [15:0]         opacity_out
);

   localparam int DS = gsaa_pkg::DIV_STEPS;
   localparam int EL = gsaa_pkg::EXP_LAT;

   gsaa_pkg::field_type neg_u;
   gsaa_pkg::exp_type   ex;
   logic [EL-1:0]       sgn_ff;
   logic [33:0]         d_ff, d_in;
   logic [48:0]         num_ff, num_in;
   logic                sg_ff;
   logic [33:0]         rem_ff [DS];
   logic [33:0]         rem_in [DS];
   logic [DS-1:0]       quo_ff [DS];
   logic [DS-1:0]       quo_in [DS];
   logic [33:0]         dv_ff  [DS];
   logic [DS-1:0]       nm_ff  [DS];
   logic [DS-1:0]       sgd_ff;
   logic [15:0]         out_ff, out_in;

   // -|v|; the most negative logit is its own negative magnitude
   assign neg_u = v_in[15] ? v_in : -v_in;

   gsaa_exp u_exp (
      .clock   (clock),
      .en      (en),
      .v_in    (neg_u),
      .res_out (ex)
   );

   always_comb begin
      logic [4:0]  sh;
      logic [33:0] rnd, e;
      sh = 5'(-ex.n);
      rnd = (sh == '0) ? '0 : (34'd1 << (sh - 5'd1));
      e = (34'(ex.m) + rnd) >> sh;
      d_in = e + (34'd1 << 32);
      num_in = (49'd1 << 48) + 49'(d_in >> 1);
   end

   always_comb begin
      logic [33:0]   pr;
      logic [33:0]   pd;
      logic [DS-1:0] pn, pq;
      logic [34:0]   rr;
      int            bt;
      for (int t = 0; t < DS; t++) begin
         bt = DS - 1 - t;
         if (t == 0) begin
            pr = 34'(num_ff[48:DS]);
            pd = d_ff;
            pn = num_ff[DS-1:0];
            pq = '0;
         end else begin
            pr = rem_ff[t-1];
            pd = dv_ff[t-1];
            pn = nm_ff[t-1];
            pq = quo_ff[t-1];
         end
         rr = {pr, pn[bt]};
         quo_in[t] = pq;
         if (rr >= 35'(pd)) begin
            rem_in[t] = 34'(rr - 35'(pd));
            quo_in[t][bt] = 1'b1;
         end else begin
            rem_in[t] = rr[33:0];
         end
      end
   end

   always_comb begin
      logic [DS-1:0] p;
      p = quo_ff[DS-1];
      if (sgd_ff[DS-1]) begin
         out_in = 16'(17'h10000 - p);
      end else begin
         out_in = p[16] ? 16'hFFFF : p[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sgn_ff <= {sgn_ff[EL-2:0], v_in[15]};
         d_ff   <= d_in;
         num_ff <= num_in;
         sg_ff  <= sgn_ff[EL-1];
         for (int t = 0; t < DS; t++) begin
            rem_ff[t] <= rem_in[t];
            quo_ff[t] <= quo_in[t];
            dv_ff[t]  <= (t == 0) ? d_ff : dv_ff[t-1];
            nm_ff[t]  <= (t == 0) ? num_ff[DS-1:0] : nm_ff[t-1];
            sgd_ff[t] <= (t == 0) ? sg_ff : sgd_ff[t-1];
         end
         out_ff <= out_in;
      end
   end

   assign opacity_out = out_ff;

endmodule
`default_nettype wire

// ===== src/gaussian_splat_attribute_activation_core.sv =====
// Top level of the Gaussian splat attribute activation pipeline.
//
//  Channel | Direction | Handshake            | Content
//  req_    | in        | req_tvalid/tready    | one splat: quaternion, log scales, harmonics, logit
//  rsp_    | out       | rsp_tvalid/tready    | activated attributes, zero-quaternion flag in tuser
//
// One splat per cycle sustained while results are taken; the delay from input transfer to result is
// set by the opacity path (41-stage exponential, one shift stage, 17-stage divider, output).
// All stages move together; a stalled result freezes the whole pipe and req_tready drops.
// Reset clears the valid bits only; there is no clearing pass and no state between splats.
`default_nettype none
module gaussian_splat_attribute_activation_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // quat_w_in, quat_x_in, quat_y_in, quat_z_in, log_scale_x, log_scale_y, log_scale_z,
   // harmonic_red, harmonic_green, harmonic_blue, opacity_logit
   input  logic [gsaa_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // quat_w_out, quat_x_out, quat_y_out, quat_z_out, scale_x, scale_y, scale_z,
   // color_red, color_green, color_blue, opacity
   output logic [gsaa_pkg::RSP_W-1:0]   rsp_tdata,
   // zero_quaternion
   output logic                         rsp_tuser
);

   localparam int PL   = gsaa_pkg::PIPE_LAT;
   localparam int QDLY = PL - gsaa_pkg::QUAT_LAT;
   localparam int SDLY = PL - gsaa_pkg::SCALE_LAT;
   localparam int CDLY = PL - gsaa_pkg::COLOR_LAT;

   logic                 pipe_en;
   logic [PL-1:0]        vld_ff;
   gsaa_pkg::quat_type   quat_res;
   gsaa_pkg::quat_type   qd_ff [QDLY];
   gsaa_pkg::exp_type    ex_s [3];
   logic [2:0][31:0]     scale_ff, scale_in;
   logic [2:0][31:0]     sd_ff [SDLY];
   logic signed [47:0]   cp_ff [3];
   logic signed [47:0]   cp_in [3];
   logic [2:0][15:0]     col_ff, col_in;
   logic [2:0][15:0]     cd_ff [CDLY];
   logic [15:0]          opac_res;

   assign rsp_tvalid = vld_ff[PL-1];
   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign req_tready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[PL-2:0], req_tvalid};
      end
   end

   gsaa_quat u_quat (
      .clock   (clock),
      .en      (pipe_en),
      .q_in    (req_tdata[63:0]),
      .res_out (quat_res)
   );

   for (genvar i = 0; i < 3; i++) begin : g_scale
      gsaa_exp u_exp (
         .clock   (clock),
         .en      (pipe_en),
         .v_in    (req_tdata[64 + 16 * i +: 16]),
         .res_out (ex_s[i])
      );
   end

   gsaa_opac u_opac (
      .clock       (clock),
      .en          (pipe_en),
      .v_in        (req_tdata[175:160]),
      .opacity_out (opac_res)
   );

   // scale = m * 2^(n-32) in Q8.24, rounded half up, saturating
   always_comb begin
      logic [5:0]  sh;
      logic [33:0] rnd, val;
      for (int i = 0; i < 3; i++) begin
         sh = 6'(6'sd8 - ex_s[i].n);
         rnd = 34'd1 << (sh - 6'd1);
         val = (34'(ex_s[i].m) + rnd) >> sh;
         if (ex_s[i].n >= 6'sd8 || val[33:32] != 2'b00) begin
            scale_in[i] = '1;
         end else begin
            scale_in[i] = val[31:0];
         end
      end
   end

   always_comb begin
      logic signed [48:0] sum;
      logic signed [17:0] cv;
      for (int i = 0; i < 3; i++) begin
         cp_in[i] = 48'(signed'(req_tdata[112 + 16 * i +: 16])) * 48'(gsaa_pkg::C0_Q32);
         sum = 49'(cp_ff[i]) + 49'sd2147483648;
         cv = 18'(sum >>> 32) + 18'sd2048;
         if (cv > 18'sd32767) begin
            col_in[i] = 16'h7FFF;
         end else if (cv < -18'sd32768) begin
            col_in[i] = 16'h8000;
         end else begin
            col_in[i] = cv[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         qd_ff[0] <= quat_res;
         for (int j = 1; j < QDLY; j++) begin
            qd_ff[j] <= qd_ff[j-1];
         end
         scale_ff <= scale_in;
         sd_ff[0] <= scale_ff;
         for (int j = 1; j < SDLY; j++) begin
            sd_ff[j] <= sd_ff[j-1];
         end
         for (int i = 0; i < 3; i++) begin
            cp_ff[i] <= cp_in[i];
         end
         col_ff   <= col_in;
         cd_ff[0] <= col_ff;
         for (int j = 1; j < CDLY; j++) begin
            cd_ff[j] <= cd_ff[j-1];
         end
      end
   end

   assign rsp_tdata = {opac_res, cd_ff[CDLY-1], sd_ff[SDLY-1], qd_ff[QDLY-1].part};
   assign rsp_tuser = qd_ff[QDLY-1].zero;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("transfer did not enter the pipe");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while result stalled");

   a_freeze_on_stall: assert property (@(posedge clock) disable iff (reset)
      !$past(pipe_en) |-> $stable(vld_ff))
      else $error("valid bits moved during stall");

   a_zero_quat_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[63:0] == 64'd0)
      else $error("zero quaternion with nonzero parts");

endmodule
`default_nettype wire
